/* rtl/core/cubic_bezier_easing_eval_top_assert.svh */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - assertion macros
// Shared assertion forms, clocked on clk_i, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_EVAL_TOP_ASSERT_SVH
`define CUBIC_BEZIER_EASING_EVAL_TOP_ASSERT_SVH

// Check a property outside of reset
`define CBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included
`define CBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/cbe_pkg.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - package
// Field widths, register reset values, queue depth and register index codes.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Port field widths
  localparam int X_W   = 19;
  localparam int CX_W  = 17;
  localparam int CY_W  = 19;
  localparam int CFG_W = 19;

  // Register reset values
  localparam logic [CX_W-1:0] CTRL1_X_RST = 17'd21845;
  localparam logic [CY_W-1:0] CTRL1_Y_RST = 19'd21845;
  localparam logic [CX_W-1:0] CTRL2_X_RST = 17'd43691;
  localparam logic [CY_W-1:0] CTRL2_Y_RST = 19'd43691;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CFG_CTRL1_X = 2'd0,
    CFG_CTRL1_Y = 2'd1,
    CFG_CTRL2_X = 2'd2,
    CFG_CTRL2_Y = 2'd3
  } cfg_idx_e;

endpackage

/* rtl/core/cbe_front.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - front end
// Holds the control points, derives curve coefficients, pins each input x
// and flags requests that bypass the solver.
// ----------------------------------------------------------------------------
module cbe_front #(
  parameter int FRAC_BITS = 16,
  parameter int RW        = 26
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [cbe_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [cbe_pkg::X_W-1:0] x_in_i,
  output logic                        push_vld_o,
  input  logic                        push_rdy_i,
  output logic [FRAC_BITS:0]          push_x_o,
  output logic                        push_byp_o,
  output logic signed [RW-1:0]        ax_o,
  output logic signed [RW-1:0]        bx_o,
  output logic signed [RW-1:0]        cx_o,
  output logic signed [RW-1:0]        ay_o,
  output logic signed [RW-1:0]        by_o,
  output logic signed [RW-1:0]        cy_o
);

  localparam int END_EPS = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam logic signed [RW-1:0] ONE_R     = RW'(1) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] LIN_R     = ONE_R >>> 6;
  localparam logic signed [RW-1:0] EPS_R     = RW'(END_EPS);
  localparam logic signed [RW-1:0] ONE_EPS_R = ONE_R - EPS_R;

  logic [cbe_pkg::CX_W-1:0] ctrl1_x_q, ctrl2_x_q;
  logic [cbe_pkg::CY_W-1:0] ctrl1_y_q, ctrl2_y_q;

  logic signed [RW-1:0] p1x, p2x, p1y, p2y, d1, d2, a1, a2;
  logic signed [RW-1:0] ax_d, bx_d, cx_d, ay_d, by_d, cy_d;
  logic signed [RW-1:0] xe, xp;
  logic                 lin;

  // Write control point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_x_q <= cbe_pkg::CTRL1_X_RST;
      ctrl1_y_q <= cbe_pkg::CTRL1_Y_RST;
      ctrl2_x_q <= cbe_pkg::CTRL2_X_RST;
      ctrl2_y_q <= cbe_pkg::CTRL2_Y_RST;
    end else if (cfg_we_i) begin
      case (cbe_pkg::cfg_idx_e'(cfg_idx_i))
        cbe_pkg::CFG_CTRL1_X: ctrl1_x_q <= cfg_data_i[cbe_pkg::CX_W-1:0];
        cbe_pkg::CFG_CTRL1_Y: ctrl1_y_q <= cfg_data_i[cbe_pkg::CY_W-1:0];
        cbe_pkg::CFG_CTRL2_X: ctrl2_x_q <= cfg_data_i[cbe_pkg::CX_W-1:0];
        cbe_pkg::CFG_CTRL2_Y: ctrl2_y_q <= cfg_data_i[cbe_pkg::CY_W-1:0];
        default: ;
      endcase
    end
  end

  // Pin control x, extend control y, derive coefficients
  always_comb begin
    p1x = $signed({{(RW-cbe_pkg::CX_W){1'b0}}, ctrl1_x_q});
    p2x = $signed({{(RW-cbe_pkg::CX_W){1'b0}}, ctrl2_x_q});
    if (p1x > ONE_R) p1x = ONE_R;
    if (p2x > ONE_R) p2x = ONE_R;
    p1y = $signed({{(RW-cbe_pkg::CY_W){ctrl1_y_q[cbe_pkg::CY_W-1]}}, ctrl1_y_q});
    p2y = $signed({{(RW-cbe_pkg::CY_W){ctrl2_y_q[cbe_pkg::CY_W-1]}}, ctrl2_y_q});
    d1  = p1x - p1y;
    d2  = p2x - p2y;
    a1  = (d1 < 0) ? -d1 : d1;
    a2  = (d2 < 0) ? -d2 : d2;
    lin = (a1 <= LIN_R) && (a2 <= LIN_R);
    ax_d = (p1x <<< 1) + p1x - ((p2x <<< 1) + p2x) + ONE_R;
    bx_d = (p2x <<< 1) + p2x - ((p1x <<< 2) + (p1x <<< 1));
    cx_d = (p1x <<< 1) + p1x;
    ay_d = (p1y <<< 1) + p1y - ((p2y <<< 1) + p2y) + ONE_R;
    by_d = (p2y <<< 1) + p2y - ((p1y <<< 2) + (p1y <<< 1));
    cy_d = (p1y <<< 1) + p1y;
  end

  // Hold coefficients for the back end
  always_ff @(posedge clk_i) begin
    ax_o <= ax_d;
    bx_o <= bx_d;
    cx_o <= cx_d;
    ay_o <= ay_d;
    by_o <= by_d;
    cy_o <= cy_d;
  end

  // Pin input x and classify the request
  always_comb begin
    xe = $signed({{(RW-cbe_pkg::X_W){x_in_i[cbe_pkg::X_W-1]}}, x_in_i});
    if (xe < 0) xp = '0;
    else if (xe > ONE_R) xp = ONE_R;
    else xp = xe;
  end

  assign push_x_o   = xp[FRAC_BITS:0];
  assign push_byp_o = lin || (xp <= EPS_R) || (xp >= ONE_EPS_R);
  assign push_vld_o = in_valid_i;
  assign in_ready_o = push_rdy_i;

endmodule

/* rtl/core/cbe_queue.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - request queue
// Short FIFO that decouples the front end from the solver pipeline.
// ----------------------------------------------------------------------------
module cbe_queue #(
  parameter int W = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_vld_i,
  output logic         push_rdy_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_vld_o,
  input  logic         pop_rdy_i,
  output logic [W-1:0] pop_data_o
);

  localparam int D  = cbe_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  mem_q [D];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_rdy_o = (cnt_q != CW'(D));
  assign pop_vld_o  = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* rtl/core/cbe_back.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - solver pipeline
// Bisection on X(t) in three multiply stages per step, a Horner pass on
// Y(t), then saturation, or the pinned x on bypass, into the output register.
// ----------------------------------------------------------------------------
module cbe_back #(
  parameter int FRAC_BITS    = 16,
  parameter int BISECT_STEPS = 16,
  parameter int RW           = 26
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_vld_i,
  output logic                           q_rdy_o,
  input  logic [FRAC_BITS:0]             q_x_i,
  input  logic                           q_byp_i,
  input  logic signed [RW-1:0]           ax_i,
  input  logic signed [RW-1:0]           bx_i,
  input  logic signed [RW-1:0]           cx_i,
  input  logic signed [RW-1:0]           ay_i,
  input  logic signed [RW-1:0]           by_i,
  input  logic signed [RW-1:0]           cy_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [cbe_pkg::X_W-1:0] y_out_o,
  output logic                           bypassed_o
);

  localparam int N  = 3 * BISECT_STEPS + 3;
  localparam int TW = FRAC_BITS + 1;
  localparam int PW = RW + TW + 1;
  localparam logic [TW-1:0]        ONE_T = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [RW-1:0] ONE_R = RW'(1) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] Y_MIN = -(ONE_R <<< 1);
  localparam logic signed [RW-1:0] Y_MAX = (ONE_R <<< 1) + ONE_R;

  logic                 vld_q [N];
  logic                 byp_q [N];
  logic [TW-1:0]        x_q   [N];
  logic [TW-1:0]        lo_q  [N];
  logic [TW-1:0]        hi_q  [N];
  logic signed [RW-1:0] r_q   [N];
  logic                 vld_d [N];
  logic                 byp_d [N];
  logic [TW-1:0]        x_d   [N];
  logic [TW-1:0]        lo_d  [N];
  logic [TW-1:0]        hi_d  [N];
  logic signed [RW-1:0] r_d   [N];

  logic                 en;
  logic                 out_vld_q;
  logic signed [cbe_pkg::X_W-1:0] y_q, y_d;
  logic                 byp_out_q;
  logic signed [RW-1:0] ysat, xo;

  // Advance the whole pipeline unless the result is stalled
  assign en      = !out_vld_q || out_ready_i;
  assign q_rdy_o = en;

  // Per-stage work: one multiply, a scale, and an add or a bisection compare where the stage needs one
  always_comb begin
    logic                 iv, ib, yph;
    logic [TW-1:0]        ix, il, ih, mid;
    logic [TW:0]          sum;
    logic signed [RW-1:0] ir, opnd, sc;
    logic signed [PW-1:0] prod;
    int                   ph;
    ph = 0;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        iv = q_vld_i;
        ib = q_byp_i;
        ix = q_x_i;
        il = '0;
        ih = ONE_T;
        ir = '0;
      end else begin
        iv = vld_q[s-1];
        ib = byp_q[s-1];
        ix = x_q[s-1];
        il = lo_q[s-1];
        ih = hi_q[s-1];
        ir = r_q[s-1];
      end
      yph  = (s >= 3 * BISECT_STEPS);
      sum  = {1'b0, il} + {1'b0, ih};
      mid  = sum[TW:1];
      opnd = (ph == 0) ? (yph ? ay_i : ax_i) : ir;
      prod = opnd * $signed({1'b0, mid});
      sc   = prod[RW+FRAC_BITS-1:FRAC_BITS];
      vld_d[s] = iv;
      byp_d[s] = ib;
      x_d[s]   = ix;
      lo_d[s]  = il;
      hi_d[s]  = ih;
      case (ph)
        0: r_d[s] = sc + (yph ? by_i : bx_i);
        1: r_d[s] = sc + (yph ? cy_i : cx_i);
        default: begin
          r_d[s] = sc;
          if (!yph) begin
            if (sc < $signed({{(RW-TW){1'b0}}, ix})) lo_d[s] = mid;
            else hi_d[s] = mid;
          end
        end
      endcase
      ph = (ph == 2) ? 0 : ph + 1;
    end
  end

  // Saturate the curve value or pass the pinned x
  always_comb begin
    ysat = r_q[N-1];
    if (ysat < Y_MIN) ysat = Y_MIN;
    if (ysat > Y_MAX) ysat = Y_MAX;
    xo   = $signed({{(RW-TW){1'b0}}, x_q[N-1]});
    y_d  = byp_q[N-1] ? xo[cbe_pkg::X_W-1:0] : ysat[cbe_pkg::X_W-1:0];
  end

  // Hold stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N; s++) vld_q[s] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[N-1];
    end
  end

  // Hold stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      byp_q     <= byp_d;
      x_q       <= x_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      r_q       <= r_d;
      y_q       <= y_d;
      byp_out_q <= byp_q[N-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign y_out_o     = y_q;
  assign bypassed_o  = byp_out_q;

endmodule

/* rtl/core/cubic_bezier_easing_eval_top.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - top level
// Solves x(t) = x on a unit-square cubic Bezier and returns y(t).
// ----------------------------------------------------------------------------
// Usage:
//   Control points are written through cfg_we_i / cfg_idx_i / cfg_data_i
//   while no request is in flight; a write lands on the same clock edge.
//   Requests enter on in_valid_i / in_ready_o with x_in_i, results leave on
//   out_valid_o / out_ready_i with y_out_o and bypassed_o, one per request,
//   in order.
//   From acceptance to out_valid_o a request passes the queue, three
//   multiply stages for each bisection step, three for the final Horner
//   pass on y, and one output stage. Throughput is one request per cycle
//   while the output is not stalled; the solver pipeline has one
//   multiplier per stage.
//   Reset clears all valid state and loads the default control points.
//   When the receiver stalls, the whole solver pipeline holds, the two-entry
//   queue fills, and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_eval_top #(
  parameter int FRAC_BITS    = 16,
  parameter int BISECT_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [cbe_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [cbe_pkg::X_W-1:0] x_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [cbe_pkg::X_W-1:0] y_out_o,
  output logic                           bypassed_o
);

  localparam int RW = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 8;
  localparam int QW = FRAC_BITS + 2;

  logic                 push_vld, push_rdy, push_byp;
  logic [FRAC_BITS:0]   push_x;
  logic                 pop_vld, pop_rdy;
  logic [QW-1:0]        pop_data;
  logic signed [RW-1:0] ax, bx, cx, ay, by, cy;

  // Classify requests and hold configuration
  cbe_front #(
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_in_i     (x_in_i),
    .push_vld_o (push_vld),
    .push_rdy_i (push_rdy),
    .push_x_o   (push_x),
    .push_byp_o (push_byp),
    .ax_o       (ax),
    .bx_o       (bx),
    .cx_o       (cx),
    .ay_o       (ay),
    .by_o       (by),
    .cy_o       (cy)
  );

  // Decouple front and back
  cbe_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (push_vld),
    .push_rdy_o  (push_rdy),
    .push_data_i ({push_byp, push_x}),
    .pop_vld_o   (pop_vld),
    .pop_rdy_i   (pop_rdy),
    .pop_data_o  (pop_data)
  );

  // Solve and evaluate
  cbe_back #(
    .FRAC_BITS    (FRAC_BITS),
    .BISECT_STEPS (BISECT_STEPS),
    .RW           (RW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (pop_vld),
    .q_rdy_o     (pop_rdy),
    .q_x_i       (pop_data[FRAC_BITS:0]),
    .q_byp_i     (pop_data[QW-1]),
    .ax_i        (ax),
    .bx_i        (bx),
    .cx_i        (cx),
    .ay_i        (ay),
    .by_i        (by),
    .cy_i        (cy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .y_out_o     (y_out_o),
    .bypassed_o  (bypassed_o)
  );

endmodule

/* rtl/core/cbe_checker.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - port checker
// Watches the top-level ports for reset, stall and bypass behavior.
// ----------------------------------------------------------------------------
`include "cubic_bezier_easing_eval_top_assert.svh"

module cbe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic signed [cbe_pkg::X_W-1:0] x_in_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [cbe_pkg::X_W-1:0] y_out_o,
  input logic                           bypassed_o
);

  // Hold a waiting request
  `CBE_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(x_in_i), "waiting request changed")

  // Hold a stalled result
  `CBE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_out_o) && $stable(bypassed_o), "stalled result changed")

  // Drop results during reset
  `CBE_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result shown in reset")

  // Pass only nonnegative x on bypass
  `CBE_ASSERT(a_byp_pos, out_valid_o && bypassed_o |-> !y_out_o[cbe_pkg::X_W-1], "bypass value negative")

endmodule

bind cubic_bezier_easing_eval_top cbe_checker u_cbe_checker (.*);

/* tb/sv/tb_cubic_bezier_easing_eval_top.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier easing evaluator - testbench
// Drives curve positions under random idling and output stalls, predicts
// each curve value with a fixed-point bisection model and checks results
// in order against it, across several control point settings.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_easing_eval_top;

  localparam longint ONE     = 64'sd1 << 16;
  localparam longint LIN_TOL = ONE >>> 6;
  localparam longint END_EPS = (ONE + 50000) / 100000;
  localparam int     STEPS   = 16;
  localparam int     DRAIN   = 80;

  typedef struct packed {
    logic signed [cbe_pkg::X_W-1:0] y_val;
    logic                           byp;
  } curve_res_t;

  // Expected curve values for accepted requests, oldest first
  class easing_scoreboard;
    curve_res_t pending[$];
    logic [cbe_pkg::CX_W-1:0] p1x_r = cbe_pkg::CTRL1_X_RST, p2x_r = cbe_pkg::CTRL2_X_RST;
    logic [cbe_pkg::CY_W-1:0] p1y_r = cbe_pkg::CTRL1_Y_RST, p2y_r = cbe_pkg::CTRL2_Y_RST;
    int errors = 0;

    function void set_reg(cbe_pkg::cfg_idx_e idx, logic [cbe_pkg::CFG_W-1:0] v);
      case (idx)
        cbe_pkg::CFG_CTRL1_X: p1x_r = v[cbe_pkg::CX_W-1:0];
        cbe_pkg::CFG_CTRL1_Y: p1y_r = v;
        cbe_pkg::CFG_CTRL2_X: p2x_r = v[cbe_pkg::CX_W-1:0];
        cbe_pkg::CFG_CTRL2_Y: p2y_r = v;
        default: ;
      endcase
    endfunction

    function longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > ONE) return ONE;
      return v;
    endfunction

    function longint fscale(longint v);
      return v >>> 16;
    endfunction

    function longint poly(longint a, longint b, longint c, longint t);
      longint r;
      r = fscale(a * t) + b;
      r = fscale(r * t) + c;
      return fscale(r * t);
    endfunction

    function longint adiff(longint a, longint b);
      return a > b ? a - b : b - a;
    endfunction

    function curve_res_t solve_curve(logic signed [cbe_pkg::X_W-1:0] xin);
      curve_res_t res;
      longint x, ax, ay, lo, hi, mid, t, y;
      longint s1x, s2x, s1y, s2y;
      x   = clamp_unit(longint'(xin));
      s1x = clamp_unit(longint'(p1x_r));
      s2x = clamp_unit(longint'(p2x_r));
      s1y = longint'($signed(p1y_r));
      s2y = longint'($signed(p2y_r));
      if ((adiff(s1x, s1y) <= LIN_TOL && adiff(s2x, s2y) <= LIN_TOL) ||
          x <= END_EPS || x >= ONE - END_EPS) begin
        res.y_val = x[cbe_pkg::X_W-1:0];
        res.byp   = 1'b1;
        return res;
      end
      ax = 3 * s1x - 3 * s2x + ONE;
      lo = 0;
      hi = ONE;
      for (int i = 0; i < STEPS; i++) begin
        mid = (lo + hi) >>> 1;
        if (poly(ax, 3 * s2x - 6 * s1x, 3 * s1x, mid) < x) lo = mid;
        else hi = mid;
      end
      t  = (lo + hi) >>> 1;
      ay = 3 * s1y - 3 * s2y + ONE;
      y  = poly(ay, 3 * s2y - 6 * s1y, 3 * s1y, t);
      if (y < -2 * ONE) y = -2 * ONE;
      if (y > 3 * ONE) y = 3 * ONE;
      res.y_val = y[cbe_pkg::X_W-1:0];
      res.byp   = 1'b0;
      return res;
    endfunction

    function void note_request(logic signed [cbe_pkg::X_W-1:0] xin);
      pending.push_back(solve_curve(xin));
    endfunction

    function void check_result(logic signed [cbe_pkg::X_W-1:0] y, logic b);
      curve_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result y=%0d bypassed=%0b", $time, y, b);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (y !== e.y_val) begin
        $display("%0t: y_out expected %0d actual %0d", $time, e.y_val, y);
        errors++;
      end
      if (b !== e.byp) begin
        $display("%0t: bypassed expected %0b actual %0b", $time, e.byp, b);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [cbe_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [cbe_pkg::X_W-1:0] x_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [cbe_pkg::X_W-1:0] y_out_o;
  logic bypassed_o;
  bit quiet_mode = 1'b0;

  easing_scoreboard sb = new();

  cubic_bezier_easing_eval_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Check results and stall the output in random bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(y_out_o, bypassed_o);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one request, with an optional idle burst first
  task automatic send_x(logic signed [cbe_pkg::X_W-1:0] xv);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_in_i     <= xv;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(xv);
  endtask

  // Wait for the pipeline to empty, then let it settle
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cbe_pkg::cfg_idx_e idx, logic [cbe_pkg::CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_curve(int a, int b, int c, int d);
    write_reg(cbe_pkg::CFG_CTRL1_X, cbe_pkg::CFG_W'(a));
    write_reg(cbe_pkg::CFG_CTRL1_Y, cbe_pkg::CFG_W'(b));
    write_reg(cbe_pkg::CFG_CTRL2_X, cbe_pkg::CFG_W'(c));
    write_reg(cbe_pkg::CFG_CTRL2_Y, cbe_pkg::CFG_W'(d));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random position: mostly inside the unit range, some out of it
  function automatic logic signed [cbe_pkg::X_W-1:0] rand_x();
    case ($urandom_range(0, 9))
      0: return cbe_pkg::X_W'($urandom);
      1: return cbe_pkg::X_W'($urandom_range(0, 3));
      2: return cbe_pkg::X_W'(65536 - $urandom_range(0, 3));
      default: return cbe_pkg::X_W'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_x(rand_x());
  endtask

  initial begin
    int dir_x[12];
    dir_x = '{0, 1, 65535, 65536, 65537, -1, -131072, 196607,
              32768, 16384, 49152, 'h2AAAA};
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default curve is linear: every request bypasses
    foreach (dir_x[i]) send_x(cbe_pkg::X_W'(dir_x[i]));
    drain_all();

    // Ease-in-out, then extreme control points with saturation
    set_curve(27525, 0, 38010, 65536);
    foreach (dir_x[i]) send_x(cbe_pkg::X_W'(dir_x[i]));
    drain_all();
    set_curve(131071, -131072, 0, 196607);
    for (int i = 0; i < 6; i++) send_x(cbe_pkg::X_W'(i * 13107 + 1));
    drain_all();
    set_curve(0, 196607, 65536, -131072);
    for (int i = 0; i < 6; i++) send_x(cbe_pkg::X_W'(i * 13107 + 1));
    run_random(200);

    // Hold the sender until all results are back
    drain_all();
    set_curve(1000, 1500, 64000, 64500);
    run_random(100);
    drain_all();

    // Random curves, random positions
    for (int k = 0; k < 8; k++) begin
      set_curve($urandom_range(0, 131071), $urandom_range(0, 524287),
                $urandom_range(0, 131071), $urandom_range(0, 524287));
      run_random(120);
      drain_all();
    end

    // Last part with no idling on either side
    quiet_mode = 1'b1;
    set_curve(16384, 80000, 50000, -20000);
    run_random(150);
    drain_all();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
